FILE: src/idt_pkg.sv
package idt_pkg;

  // Default geometry of the indentation stack
  localparam int STACK_DEPTH_DEF = 16;
  localparam int COLUMN_BITS_DEF = 8;

  // Fixed field widths of the two channels
  localparam int LINE_KIND_W    = 2;
  localparam int LINE_INDENT_W  = 8;
  localparam int TOKEN_KIND_W   = 3;
  localparam int INDENT_WIDTH_W = 8;

  // Line kinds
  localparam logic [LINE_KIND_W-1:0] LK_CODE  = 2'd0;
  localparam logic [LINE_KIND_W-1:0] LK_BLANK = 2'd1;
  localparam logic [LINE_KIND_W-1:0] LK_CONT  = 2'd2;
  localparam logic [LINE_KIND_W-1:0] LK_END   = 2'd3;

  // Token kinds
  localparam logic [TOKEN_KIND_W-1:0] TK_INDENT    = 3'd0;
  localparam logic [TOKEN_KIND_W-1:0] TK_DEDENT    = 3'd1;
  localparam logic [TOKEN_KIND_W-1:0] TK_ENDMARKER = 3'd2;
  localparam logic [TOKEN_KIND_W-1:0] TK_MISMATCH  = 3'd3;
  localparam logic [TOKEN_KIND_W-1:0] TK_OVERFLOW  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                    load;
    logic                    emit;
    logic [TOKEN_KIND_W-1:0] emit_kind;
    logic                    emit_last;
    logic                    push;
    logic                    pop;
    logic                    clear;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [LINE_KIND_W-1:0] kind;
    logic                   col_gt;
    logic                   col_lt;
    logic                   top_zero;
    logic                   top_one;
    logic                   top_full;
    logic                   pop_more;
    logic                   pop_match;
    logic                   out_free;
  } sts_t;

endpackage

FILE: src/idt_ctrl.sv
module idt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  idt_pkg::sts_t sts,
  output idt_pkg::cmd_t cmd
);
  import idt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_DEDENT   = 3'd2;
  localparam logic [2:0] S_MISMATCH = 3'd3;
  localparam logic [2:0] S_END_DED  = 3'd4;
  localparam logic [2:0] S_ENDMARK  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = TK_DEDENT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.kind)
          LK_END: begin
            state_nxt = sts.top_zero ? S_ENDMARK : S_END_DED;
          end
          LK_CODE: begin
            if (sts.col_gt) begin
              if (sts.out_free) begin
                cmd.emit      = 1'b1;
                cmd.emit_last = 1'b1;
                cmd.emit_kind = sts.top_full ? TK_OVERFLOW : TK_INDENT;
                cmd.push      = !sts.top_full;
                state_nxt     = S_IDLE;
              end
            end else if (sts.col_lt) begin
              state_nxt = S_DEDENT;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_DEDENT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.pop       = 1'b1;
          cmd.emit_kind = TK_DEDENT;
          cmd.emit_last = !sts.pop_more && sts.pop_match;
          if (sts.pop_more) begin
            state_nxt = S_DEDENT;
          end else if (sts.pop_match) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MISMATCH;
          end
        end
      end
      S_MISMATCH: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = TK_MISMATCH;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_END_DED: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.pop       = 1'b1;
          cmd.emit_kind = TK_DEDENT;
          if (sts.top_one) begin
            state_nxt = S_ENDMARK;
          end
        end
      end
      S_ENDMARK: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = TK_ENDMARKER;
          cmd.emit_last = 1'b1;
          cmd.clear     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/idt_datapath.sv
module idt_datapath #(
  parameter int STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF,
  parameter int COLUMN_BITS = idt_pkg::COLUMN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [idt_pkg::LINE_KIND_W-1:0]     in_line_kind,
  input  logic [idt_pkg::LINE_INDENT_W-1:0]   in_line_indent,
  input  idt_pkg::cmd_t                       cmd,
  output idt_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [idt_pkg::TOKEN_KIND_W-1:0]    out_token_kind,
  output logic [idt_pkg::INDENT_WIDTH_W-1:0]  out_indent_width,
  output logic                                out_last
);
  import idt_pkg::*;

  localparam int IDX_W = $clog2(STACK_DEPTH);

  // Stack entries above the bottom; entry zero is never written or relied upon.
  logic [COLUMN_BITS-1:0] stack_mem [STACK_DEPTH];

  logic [IDX_W-1:0]       top_r, top_nxt;
  logic [COLUMN_BITS-1:0] top_col_r, top_col_nxt;
  logic [COLUMN_BITS-1:0] below_col_r;
  logic [COLUMN_BITS-1:0] col_r;
  logic [LINE_KIND_W-1:0] kind_r;
  logic [IDX_W-1:0]       rd_addr;
  logic [COLUMN_BITS-1:0] col_after_pop;

  logic                      out_valid_r;
  logic [TOKEN_KIND_W-1:0]   out_kind_r;
  logic [INDENT_WIDTH_W-1:0] out_width_r;
  logic                      out_last_r;

  // While popping, fetch two below the top so that the entry under the new
  // top is ready in the following cycle.
  assign rd_addr       = cmd.pop ? (top_r - IDX_W'(2)) : (top_r - IDX_W'(1));
  assign col_after_pop = sts.top_one ? '0 : below_col_r;

  always_comb begin
    sts           = '0;
    sts.kind      = kind_r;
    sts.col_gt    = col_r > top_col_r;
    sts.col_lt    = col_r < top_col_r;
    sts.top_zero  = (top_r == '0);
    sts.top_one   = (top_r == IDX_W'(1));
    sts.top_full  = (top_r == IDX_W'(STACK_DEPTH - 1));
    sts.pop_more  = !sts.top_one && (col_r < below_col_r);
    sts.pop_match = (col_r == col_after_pop);
    sts.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    top_nxt     = top_r;
    top_col_nxt = top_col_r;
    if (cmd.clear) begin
      top_nxt     = '0;
      top_col_nxt = '0;
    end else if (cmd.push) begin
      top_nxt     = top_r + IDX_W'(1);
      top_col_nxt = col_r;
    end else if (cmd.pop) begin
      top_nxt     = top_r - IDX_W'(1);
      top_col_nxt = col_after_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stack_mem[top_r + IDX_W'(1)] <= col_r;
    end
    below_col_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_line_kind;
      col_r  <= COLUMN_BITS'(in_line_indent);
    end
    if (cmd.emit) begin
      out_kind_r  <= cmd.emit_kind;
      out_width_r <= (cmd.emit_kind == TK_INDENT) ? INDENT_WIDTH_W'(col_r) : '0;
      out_last_r  <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      top_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r     <= top_nxt;
      top_col_r <= top_col_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_kind_r;
  assign out_indent_width = out_width_r;
  assign out_last         = out_last_r;

endmodule

FILE: src/indent_dedent_tracker_top.sv
// Indentation tracker: takes one logical-line descriptor per transaction and
// produces INDENT, DEDENT, ENDMARKER, dedent-mismatch and stack-overflow tokens,
// with out_last set on the final token of each line. One line is handled at a
// time: in_stall stays high until the line is done. The stack memory pops one
// level per cycle while the output is free, and a stalled output holds the pops
// back. STACK_DEPTH bounds the nesting (STACK_DEPTH - 1 levels above column
// zero); COLUMN_BITS sets the column width kept on the stack. No initialisation
// pass is needed after reset.
module indent_dedent_tracker_top #(
  parameter int STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF,
  parameter int COLUMN_BITS = idt_pkg::COLUMN_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [idt_pkg::LINE_KIND_W-1:0]     in_line_kind,
  input  logic [idt_pkg::LINE_INDENT_W-1:0]   in_line_indent,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [idt_pkg::TOKEN_KIND_W-1:0]    out_token_kind,
  output logic [idt_pkg::INDENT_WIDTH_W-1:0]  out_indent_width,
  output logic                                out_last
);
  import idt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  idt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  idt_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_line_kind     (in_line_kind),
    .in_line_indent   (in_line_indent),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_indent_width (out_indent_width),
    .out_last         (out_last)
  );

endmodule

FILE: src/idt_checker.sv
module idt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [idt_pkg::TOKEN_KIND_W-1:0]    out_token_kind,
  input logic [idt_pkg::INDENT_WIDTH_W-1:0]  out_indent_width,
  input logic                                out_last
);
  import idt_pkg::*;

  // A line is worked on alone, so an accepted transaction blocks the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after an accepted line");

  // Only INDENT carries a column.
  a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind != TK_INDENT) |-> (out_indent_width == '0))
    else $error("non-INDENT token carries a column");

  // Only DEDENT may be followed by more tokens of the same line.
  a_last_token: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind != TK_DEDENT) |-> out_last)
    else $error("terminal token without last");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_token_kind) && $stable(out_indent_width) &&
       $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind indent_dedent_tracker_top idt_checker u_idt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_token_kind   (out_token_kind),
  .out_indent_width (out_indent_width),
  .out_last         (out_last)
);

FILE: tb/indent_dedent_checker.sv
module indent_dedent_checker
  import idt_pkg::*;
#(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [LINE_KIND_W-1:0]    in_line_kind,
  input  logic [LINE_INDENT_W-1:0]  in_line_indent,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [TOKEN_KIND_W-1:0]   out_token_kind,
  input  logic [INDENT_WIDTH_W-1:0] out_indent_width,
  input  logic                      out_last,
  output int                        errors,
  output int                        pending,
  output int                        lines_seen,
  output int                        tokens_seen,
  output int                        mismatch_tokens,
  output int                        overflow_tokens
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TOKEN_KIND_W-1:0]   kind;
    logic [INDENT_WIDTH_W-1:0] width;
    logic                      last;
  } token_t;

  token_t expected_tokens[$];

  // Our own copy of the indentation stack; entry zero always holds column zero.
  logic [LINE_INDENT_W-1:0] levels[DEPTH];
  int unsigned              top_idx;

  // The newest token of a line is held back until the line is complete, so
  // that its last flag can be set before it is queued.
  token_t held_token;
  bit     held_valid;

  task automatic queue_token(input logic [TOKEN_KIND_W-1:0] kind,
                             input logic [INDENT_WIDTH_W-1:0] width);
    if (held_valid) expected_tokens = {expected_tokens, held_token};
    held_token = '{kind: kind, width: width, last: 1'b0};
    held_valid = 1'b1;
  endtask

  task automatic clear_levels();
    foreach (levels[i]) levels[i] = '0;
    top_idx = 0;
  endtask

  task automatic track_line(input logic [LINE_KIND_W-1:0] kind,
                            input logic [LINE_INDENT_W-1:0] col);
    held_valid = 1'b0;
    case (kind)
      LK_END: begin
        while (top_idx > 0) begin
          queue_token(TK_DEDENT, '0);
          top_idx--;
        end
        queue_token(TK_ENDMARKER, '0);
        clear_levels();
      end
      LK_CODE: begin
        if (col > levels[top_idx]) begin
          if (top_idx == DEPTH - 1) begin
            queue_token(TK_OVERFLOW, '0);
          end else begin
            top_idx++;
            levels[top_idx] = col;
            queue_token(TK_INDENT, col);
          end
        end else if (col < levels[top_idx]) begin
          while (top_idx > 0 && col < levels[top_idx]) begin
            top_idx--;
            queue_token(TK_DEDENT, '0);
          end
          if (col != levels[top_idx]) queue_token(TK_MISMATCH, '0);
        end
      end
      default: ;
    endcase
    if (held_valid) begin
      held_token.last = 1'b1;
      expected_tokens = {expected_tokens, held_token};
    end
  endtask

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) $display("[%0t] token check: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    token_t got;
    token_t want;
    if (!rst_n) begin
      expected_tokens.delete();
      clear_levels();
      held_valid      = 1'b0;
      errors          = 0;
      lines_seen      = 0;
      tokens_seen     = 0;
      mismatch_tokens = 0;
      overflow_tokens = 0;
    end else begin
      // A token at this edge always belongs to a line accepted earlier.
      if (out_valid && !out_stall) begin
        got = '{kind: out_token_kind, width: out_indent_width, last: out_last};
        tokens_seen++;
        if (got.kind == TK_MISMATCH) mismatch_tokens++;
        if (got.kind == TK_OVERFLOW) overflow_tokens++;
        if (expected_tokens.size() == 0) begin
          note_failure($sformatf("kind %0d width %0d last %0d arrived with none expected",
                                 got.kind, got.width, got.last));
        end else begin
          want = expected_tokens.pop_front();
          if (got.kind !== want.kind || got.width !== want.width ||
              got.last !== want.last)
            note_failure($sformatf(
              "expected kind %0d width %0d last %0d, got kind %0d width %0d last %0d",
              want.kind, want.width, want.last, got.kind, got.width, got.last));
        end
      end
      if (in_valid && !in_stall) begin
        lines_seen++;
        track_line(in_line_kind, in_line_indent);
      end
    end
    pending = expected_tokens.size();
  end

endmodule

FILE: tb/indent_dedent_tracker_top_tb.sv
module indent_dedent_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import idt_pkg::*;

  localparam int DEPTH       = STACK_DEPTH_DEF;
  localparam int RANDOM_LINES = 155;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [LINE_KIND_W-1:0]    in_line_kind;
  logic [LINE_INDENT_W-1:0]  in_line_indent;
  logic                      out_valid;
  logic                      out_stall;
  logic [TOKEN_KIND_W-1:0]   out_token_kind;
  logic [INDENT_WIDTH_W-1:0] out_indent_width;
  logic                      out_last;

  int errors, pending, lines_seen, tokens_seen, mismatch_tokens, overflow_tokens;

  bit random_phase;
  int burst_left;

  // Stack of columns as the stimulus believes it to be, used only to steer
  // the random lines towards well-formed indentation.
  int shadow_cols[DEPTH];
  int shadow_top;

  indent_dedent_tracker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_kind     (in_line_kind),
    .in_line_indent   (in_line_indent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_indent_width (out_indent_width),
    .out_last         (out_last)
  );

  indent_dedent_checker #(.DEPTH(DEPTH)) checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line_kind     (in_line_kind),
    .in_line_indent   (in_line_indent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_indent_width (out_indent_width),
    .out_last         (out_last),
    .errors           (errors),
    .pending          (pending),
    .lines_seen       (lines_seen),
    .tokens_seen      (tokens_seen),
    .mismatch_tokens  (mismatch_tokens),
    .overflow_tokens  (overflow_tokens)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Timed out with %0d tokens still awaited.", pending);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one line; the sender works in bursts with random gaps between them.
  task automatic offer_line(input logic [LINE_KIND_W-1:0] kind, input int col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_line_kind   <= kind;
    in_line_indent <= col[LINE_INDENT_W-1:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic void shadow_code(input int col);
    if (col > shadow_cols[shadow_top]) begin
      if (shadow_top < DEPTH - 1) begin
        shadow_top++;
        shadow_cols[shadow_top] = col;
      end
    end else begin
      while (shadow_top > 0 && col < shadow_cols[shadow_top]) shadow_top--;
    end
  endfunction

  function automatic int deeper_col();
    int step;
    step = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
    if (shadow_cols[shadow_top] + step > 255) return 255;
    return shadow_cols[shadow_top] + step;
  endfunction

  task automatic send_code(input int col);
    offer_line(LK_CODE, col);
    shadow_code(col);
  endtask

  task automatic random_line(inout int sent);
    int r;
    int k;
    int lo;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // Nest towards a full stack, then offer one deeper level, refused if the stack is full.
      while (shadow_top < DEPTH - 1 && shadow_cols[shadow_top] < 250 &&
             sent < RANDOM_LINES) begin
        send_code(shadow_cols[shadow_top] + $urandom_range(1, 4));
        sent++;
      end
      send_code(deeper_col());
    end else if (r < 10) begin
      offer_line(LK_END, $urandom_range(0, 255));
      shadow_top = 0;
    end else if (r < 22) begin
      offer_line($urandom_range(0, 1) ? LK_BLANK : LK_CONT, $urandom_range(0, 255));
    end else if (r < 47) begin
      send_code(deeper_col());
    end else if (r < 60) begin
      send_code(shadow_cols[shadow_top]);
    end else if (r < 78) begin
      k = $urandom_range(0, shadow_top);
      send_code(shadow_cols[k]);
    end else if (r < 90) begin
      // Aim between two stacked columns so that the dedent lands off the stack.
      if (shadow_top > 0) begin
        k = $urandom_range(1, shadow_top);
        lo = shadow_cols[k - 1] + 1;
        send_code(lo < shadow_cols[k] ? $urandom_range(lo, shadow_cols[k] - 1)
                                      : $urandom_range(0, 255));
      end else begin
        send_code($urandom_range(0, 255));
      end
    end else begin
      send_code($urandom_range(0, 255));
    end
    sent++;
  endtask

  // Receiver: stall pattern of its own, plus one long hold-off early in the
  // random part so that the block backs up and stalls its input.
  initial begin
    int mode;
    int span;
    bit held_off;
    out_stall = 1'b0;
    held_off  = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (random_phase && !held_off) begin
        held_off = 1'b1;
        out_stall <= 1'b0;
        repeat (30) @(negedge clk);
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
      end
      span = $urandom_range(5, 60);
      mode = $urandom_range(0, 2);
      repeat (span) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    int sent;
    in_valid       = 1'b0;
    in_line_kind   = LK_BLANK;
    in_line_indent = '0;
    rst_n          = 1'b0;
    random_phase   = 1'b0;
    burst_left     = 0;
    shadow_top     = 0;
    foreach (shadow_cols[i]) shadow_cols[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: equal column, ignored lines, indent, dedent onto a column
    // that is not on the stack, the widest column, a multi-level dedent, a
    // full stack refusing one more level, and end of input from full depth.
    send_code(0);
    offer_line(LK_BLANK, 255);
    offer_line(LK_CONT, 170);
    send_code(4);
    send_code(8);
    send_code(6);
    send_code(255);
    send_code(0);
    for (int c = 1; c < DEPTH; c++) send_code(c);
    send_code(DEPTH);
    offer_line(LK_END, 0);
    shadow_top = 0;

    random_phase = 1'b1;
    sent = 0;
    while (sent < RANDOM_LINES) random_line(sent);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run covered %0d lines and %0d tokens, among them %0d dedent mismatches",
             lines_seen, tokens_seen, mismatch_tokens);
    $display("and %0d stack overflows; %0d token checks failed.", overflow_tokens, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/idt_pkg.sv
src/idt_ctrl.sv
src/idt_datapath.sv
src/indent_dedent_tracker_top.sv
src/idt_checker.sv
tb/indent_dedent_checker.sv
tb/indent_dedent_tracker_top_tb.sv
